// ----- hw/rtl/b64lw_pkg.sv -----
// Shared types and constants of the line-wrapped base64 encoder.
// Holds the command record that passes from the front to the back and the alphabet lookup.
// No dependencies.
`timescale 1ns / 1ps

package b64lw_pkg;

    localparam logic [7:0] WRAP_RESET = 8'd72;
    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] LF_CHAR    = 8'h0A;

    // Maximum characters that one input byte can produce
    localparam int MAX_CHARS = 5;
    localparam int IDX_W     = $clog2(MAX_CHARS);
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    // Command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Group phase codes
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // One accepted byte, turned into the characters it emits
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          num;
        logic                      last;
    } cmd_t;

    // Map a six-bit value onto the standard alphabet
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] r;
        w = {2'b00, v};
        if (v < 6'd26)
            r = 8'h41 + w;
        else if (v < 6'd52)
            r = 8'h61 + w - 8'd26;
        else if (v < 6'd62)
            r = 8'h30 + w - 8'd52;
        else if (v == 6'd62)
            r = 8'h2B;
        else
            r = 8'h2F;
        return r;
    endfunction

endpackage

// ----- hw/rtl/b64lw_front.sv -----
// Front of the encoder: accepts message bytes, tracks group phase and line count,
// and builds one command record per byte. Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic [7:0]      cfg_data,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            end_of_message,
    output b64lw_pkg::cmd_t cmd
);

    logic [7:0] wrap_reg;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [7:0] line_reg;
    logic [7:0] line_next;
    logic [8:0] line_sum;
    logic       wrap_hit;

    // Count after a full group, compared without overflow
    assign line_sum = {1'b0, line_reg} + 9'd4;
    assign wrap_hit = (line_sum >= {1'b0, wrap_reg});

    // Classify the byte by phase and build its characters
    always_comb
    begin
        cmd        = '0;
        cmd.last   = end_of_message;
        held_next  = data_byte;
        phase_next = phase_reg;
        line_next  = line_reg;
        unique case (phase_reg)
            b64lw_pkg::PHASE_1:
            begin
                cmd.chars[0] = b64lw_pkg::sym({held_reg[1:0], data_byte[7:4]});
                cmd.chars[1] = b64lw_pkg::sym({data_byte[3:0], 2'b00});
                cmd.chars[2] = b64lw_pkg::PAD_CHAR;
                cmd.chars[3] = b64lw_pkg::LF_CHAR;
                cmd.num      = end_of_message ? b64lw_pkg::CNT_W'(4) : b64lw_pkg::CNT_W'(1);
                phase_next   = b64lw_pkg::PHASE_2;
            end
            b64lw_pkg::PHASE_2:
            begin
                cmd.chars[0] = b64lw_pkg::sym({held_reg[3:0], data_byte[7:6]});
                cmd.chars[1] = b64lw_pkg::sym(data_byte[5:0]);
                cmd.chars[2] = b64lw_pkg::LF_CHAR;
                line_next    = wrap_hit ? 8'd0 : line_sum[7:0];
                // Wrap feed and closing feed never both occur
                cmd.num      = (wrap_hit || (end_of_message && (line_sum[7:0] != 8'd0)))
                             ? b64lw_pkg::CNT_W'(3) : b64lw_pkg::CNT_W'(2);
                held_next    = 8'd0;
                phase_next   = b64lw_pkg::PHASE_0;
            end
            default:
            begin
                cmd.chars[0] = b64lw_pkg::sym(data_byte[7:2]);
                cmd.chars[1] = b64lw_pkg::sym({data_byte[1:0], 4'b0000});
                cmd.chars[2] = b64lw_pkg::PAD_CHAR;
                cmd.chars[3] = b64lw_pkg::PAD_CHAR;
                cmd.chars[4] = b64lw_pkg::LF_CHAR;
                cmd.num      = end_of_message ? b64lw_pkg::CNT_W'(5) : b64lw_pkg::CNT_W'(1);
                phase_next   = b64lw_pkg::PHASE_1;
            end
        endcase
        // Drop message state at its end
        if (end_of_message)
        begin
            held_next  = 8'd0;
            phase_next = b64lw_pkg::PHASE_0;
            line_next  = 8'd0;
        end
    end

    // Hold wrap length until written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wrap_reg <= b64lw_pkg::WRAP_RESET;
        else if (cfg_write)
            wrap_reg <= cfg_data;
    end

    // Advance message state on each transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 8'd0;
            phase_reg <= b64lw_pkg::PHASE_0;
            line_reg  <= 8'd0;
        end
        else if (accept)
        begin
            held_reg  <= held_next;
            phase_reg <= phase_next;
            line_reg  <= line_next;
        end
    end

endmodule

// ----- hw/rtl/b64lw_cmd_fifo.sv -----
// Short command queue that decouples the encoder front from the character back end.
// Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  b64lw_pkg::cmd_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output b64lw_pkg::cmd_t rd_data,
    output logic            empty
);

    b64lw_pkg::cmd_t                   entry_reg [b64lw_pkg::CMD_DEPTH];
    logic [b64lw_pkg::CMD_PTR_W-1:0]   wr_ptr_reg;
    logic [b64lw_pkg::CMD_PTR_W-1:0]   rd_ptr_reg;
    logic [b64lw_pkg::CMD_CNT_W-1:0]   count_reg;

    assign full    = (count_reg == b64lw_pkg::CMD_CNT_W'(b64lw_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hw/rtl/b64lw_back.sv -----
// Back end of the encoder: walks the characters of each queued command, one per cycle while the
// receiver keeps popping, into an output register. Depends on b64lw_pkg.
`timescale 1ns / 1ps

module b64lw_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  b64lw_pkg::cmd_t cmd,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    output logic [7:0]      out_char,
    output logic            last_char,
    output logic            empty,
    input  logic            pop
);

    logic [b64lw_pkg::IDX_W-1:0] idx_reg;
    logic                        valid_reg;
    logic [7:0]                  char_reg;
    logic                        last_reg;
    logic                        load;
    logic                        final_one;

    // Load a character when the output slot is free or being taken
    assign load      = !cmd_empty && (!valid_reg || pop);
    assign final_one = (b64lw_pkg::CNT_W'(idx_reg) == (cmd.num - b64lw_pkg::CNT_W'(1)));
    assign cmd_pop   = load && final_one;

    assign out_char  = char_reg;
    assign last_char = last_reg;
    assign empty     = !valid_reg;

    // Step through the command's characters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (load)
            idx_reg <= final_one ? '0 : idx_reg + 1'b1;
    end

    // Hold or replace the output transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (pop)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= cmd.chars[idx_reg];
            last_reg <= cmd.last && final_one;
        end
    end

endmodule

// ----- hw/rtl/base64_line_wrapped_encoder_core.sv -----
// Line-wrapped base64 encoder: one message byte in, one to five characters out.
// Each byte's command record is written into the command queue, then its characters go to the output register.
// Throughput: one character per cycle through the single output register while the receiver pops;
// a byte emits one to five characters, and new bytes are taken while the command queue is not full.
// Reset clears group phase, held byte, line count and queues; wrap length returns to 72.
`timescale 1ns / 1ps

module base64_line_wrapped_encoder_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       last_char
);

    b64lw_pkg::cmd_t front_cmd;
    b64lw_pkg::cmd_t head_cmd;
    logic            accept;
    logic            cmd_empty;
    logic            cmd_pop;

    assign accept = push && !full;

    b64lw_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .accept         (accept),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .cmd            (front_cmd)
    );

    b64lw_cmd_fifo u_cmd_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (head_cmd),
        .empty   (cmd_empty)
    );

    b64lw_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_char  (out_char),
        .last_char (last_char),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// ----- tb/sv/b64lw_stream_check.sv -----
// Stream checker for the line-wrapped base64 encoder: watches the byte, character and
// wrap-length ports, predicts each character and compares it with what the block emits.
// Depends on b64lw_pkg for the phase, pad and line feed constants.
`timescale 1ns / 1ps

module b64lw_stream_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_char,
    input  logic        last_char,
    output logic [31:0] fail_count,
    output logic [31:0] pending,
    output logic [31:0] bytes_seen,
    output logic [31:0] msgs_seen,
    output logic [31:0] chars_checked
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_rec_t;

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Predicted encoder state
    logic [7:0] wrap_len;
    logic [7:0] prev_byte;
    logic [1:0] phase;
    logic [7:0] line_cnt;

    char_rec_t  expected_chars[$];
    int         errors;
    int         n_bytes;
    int         n_msgs;
    int         n_chars;

    assign fail_count    = errors;
    assign bytes_seen    = n_bytes;
    assign msgs_seen     = n_msgs;
    assign chars_checked = n_chars;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        int idx;
        idx = 8 * (63 - int'(v));
        return ALPHABET[idx +: 8];
    endfunction

    // Work out the characters one byte produces and queue them
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        logic [7:0] chars [0:4];
        int         n;
        int         cnt;
        char_rec_t  rec;
        n = 0;
        case (phase)
            b64lw_pkg::PHASE_1:
            begin
                chars[0] = b64_char({prev_byte[1:0], b[7:4]});
                n = 1;
                if (eom)
                begin
                    chars[1] = b64_char({b[3:0], 2'b00});
                    chars[2] = b64lw_pkg::PAD_CHAR;
                    chars[3] = b64lw_pkg::LF_CHAR;
                    n = 4;
                end
                else
                begin
                    prev_byte = b;
                    phase     = b64lw_pkg::PHASE_2;
                end
            end
            b64lw_pkg::PHASE_2:
            begin
                chars[0] = b64_char({prev_byte[3:0], b[7:6]});
                chars[1] = b64_char(b[5:0]);
                n = 2;
                // Compare in full width so a count past 255 still wraps
                cnt = int'(line_cnt) + 4;
                if (cnt >= int'(wrap_len))
                begin
                    chars[2] = b64lw_pkg::LF_CHAR;
                    n = 3;
                    cnt = 0;
                end
                line_cnt  = cnt[7:0];
                prev_byte = 8'h00;
                phase     = b64lw_pkg::PHASE_0;
                if (eom && line_cnt != 8'd0)
                begin
                    chars[n] = b64lw_pkg::LF_CHAR;
                    n = n + 1;
                end
            end
            default:
            begin
                chars[0] = b64_char(b[7:2]);
                n = 1;
                if (eom)
                begin
                    chars[1] = b64_char({b[1:0], 4'b0000});
                    chars[2] = b64lw_pkg::PAD_CHAR;
                    chars[3] = b64lw_pkg::PAD_CHAR;
                    chars[4] = b64lw_pkg::LF_CHAR;
                    n = 5;
                end
                else
                begin
                    prev_byte = b;
                    phase     = b64lw_pkg::PHASE_1;
                end
            end
        endcase
        if (eom)
        begin
            prev_byte = 8'h00;
            phase     = b64lw_pkg::PHASE_0;
            line_cnt  = 8'd0;
            n_msgs    = n_msgs + 1;
        end
        for (int i = 0; i < n; i++)
        begin
            rec.ch   = chars[i];
            rec.last = eom && (i == n - 1);
            expected_chars.push_back(rec);
        end
        n_bytes = n_bytes + 1;
    endtask

    // Compare one emitted character with the oldest prediction
    task automatic check_char();
        char_rec_t want;
        if (expected_chars.size() == 0)
        begin
            $error("unexpected character %h (last_char %b) with nothing predicted",
                   out_char, last_char);
            errors = errors + 1;
        end
        else
        begin
            want    = expected_chars.pop_front();
            n_chars = n_chars + 1;
            if (out_char !== want.ch)
            begin
                $error("out_char mismatch: expected %h, actual %h", want.ch, out_char);
                errors = errors + 1;
            end
            if (last_char !== want.last)
            begin
                $error("last_char mismatch: expected %b, actual %b", want.last, last_char);
                errors = errors + 1;
            end
        end
    endtask

    // Track each transaction on every channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_len  = b64lw_pkg::WRAP_RESET;
            prev_byte = 8'h00;
            phase     = b64lw_pkg::PHASE_0;
            line_cnt  = 8'd0;
            expected_chars.delete();
            pending <= '0;
        end
        else
        begin
            if (cfg_write)
                wrap_len = cfg_data;
            if (push && !full)
                encode_byte(data_byte, end_of_message);
            if (pop && !empty)
                check_char();
            pending <= expected_chars.size();
        end
    end

    initial
    begin
        errors  = 0;
        n_bytes = 0;
        n_msgs  = 0;
        n_chars = 0;
    end

endmodule

// ----- tb/sv/base64_line_wrapped_encoder_core_tb.sv -----
// Top of the line-wrapped base64 encoder testbench: clock, reset, byte stimulus,
// receiver stalls, wrap-length writes, watchdog and verdict.
// Depends on b64lw_pkg, base64_line_wrapped_encoder_core and b64lw_stream_check.
`timescale 1ns / 1ps

module base64_line_wrapped_encoder_core_tb;

    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_message = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_char;
    logic        last_char;

    logic [31:0] fail_count;
    logic [31:0] pending;
    logic [31:0] bytes_seen;
    logic [31:0] msgs_seen;
    logic [31:0] chars_checked;

    int          items_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    base64_line_wrapped_encoder_core DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop),
        .out_char       (out_char),
        .last_char      (last_char)
    );

    b64lw_stream_check stream_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop),
        .out_char       (out_char),
        .last_char      (last_char),
        .fail_count     (fail_count),
        .pending        (pending),
        .bytes_seen     (bytes_seen),
        .msgs_seen      (msgs_seen),
        .chars_checked  (chars_checked)
    );

    always #6 clk = ~clk;

    // Offer one byte, in bursts separated by random gaps; hold until accepted
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left = burst_left - 1;
        push           <= 1'b1;
        data_byte      <= b;
        end_of_message <= eom;
        do @(posedge clk); while (full);
        items_sent = items_sent + 1;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // Stop sending and wait until every predicted character has come out
    task automatic drain_encoder();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_wrap(input logic [7:0] v);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // One wrap setting with messages of mostly short, sometimes longer lengths
    task automatic random_phase(input logic [7:0] wrap, input int n_items, input int max_len);
        int sent;
        int len;
        drain_encoder();
        set_wrap(wrap);
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, max_len)
                                               : $urandom_range(1, 6);
            send_message(len);
            sent = sent + len;
        end
    endtask

    // Receiver: randomly chosen stall patterns, plus one long hold-off
    initial
    begin : receiver
        int mode;
        int cyc;
        int hold_left;
        bit hold_done;
        mode = 0;
        cyc = 0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc = cyc + 1;
            if (cyc % 50 == 0)
                mode = $urandom_range(0, 3);
            if (!hold_done && items_sent >= 60)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 1) == 1);
                    2: pop <= (cyc % 4 == 0);
                    default: pop <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if no transaction happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] w;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte message: two pads; two bytes: one pad; full group: closing line feed
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFC, 1'b0);
        send_byte(8'h03, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);

        // Shortest wrap: the wrap line feed ends the message, no second one
        drain_encoder();
        set_wrap(8'd4);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);

        // Wrap length of zero wraps after every group
        drain_encoder();
        set_wrap(8'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hEE, 1'b0);
        send_byte(8'hDD, 1'b0);
        send_byte(8'h11, 1'b1);

        // Change the wrap length in the middle of a message
        drain_encoder();
        set_wrap(8'd8);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        drain_encoder();
        set_wrap(8'd4);
        send_byte(8'h40, 1'b0);
        send_byte(8'h50, 1'b0);
        send_byte(8'h60, 1'b1);

        // Long line at the top wrap length: the count passes 252 before it wraps
        drain_encoder();
        set_wrap(8'd255);
        send_message(195);

        random_phase(8'd4, 20, 9);
        random_phase(8'd252, 20, 30);
        random_phase(8'd1, 12, 8);
        w = 8'($urandom_range(5, 80));
        random_phase(w, 20, 24);
        w = 8'($urandom_range(0, 255));
        random_phase(w, 15, 12);
        random_phase(8'd72, 15, 20);

        drain_encoder();
        repeat (10) @(posedge clk);

        $display("Run covered %0d bytes in %0d messages, %0d characters compared,",
                 bytes_seen, msgs_seen, chars_checked);
        $display("wrap lengths 0 through 255, receiver stalls and a backed-up input.");
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
